// File: design/lpdd_pkg.sv
// package for the linear probe duplicate detector
// holds payload structs, controller commands and status, state codes and hash constants
// no dependencies
package lpdd_pkg;

  localparam int unsigned NUM_SLOTS_DEF  = 1024;
  localparam int unsigned ID_W           = 64;
  localparam int unsigned HALF_W         = ID_W / 2;
  localparam int unsigned HASH_SHIFT     = 33;
  localparam logic [ID_W-1:0] HASH_MUL   = 64'hff51afd7ed558ccd;
  localparam int unsigned MUL_STEPS      = 3;
  localparam int unsigned RED_STEPS      = 3;

  localparam logic [1:0] ST_NEW  = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0] id_low;
    logic [ID_W-1:0] id_high;
    logic            first_of_set;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       all_distinct;
  } result_t;

  typedef struct packed {
    logic load;
    logic clear_step;
    logic mul_step;
    logic reduce_step;
    logic read;
    logic check;
  } cmd_t;

  typedef struct packed {
    logic wipe_needed;
    logic clear_last;
    logic mul_last;
    logic reduce_last;
    logic hit_empty;
    logic hit_match;
    logic probe_last;
  } stat_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_WIPE,
    S_MUL,
    S_REDUCE,
    S_READ,
    S_CHECK
  } state_t;

endpackage

// File: design/lpdd_ctrl.sv
// controller state machine for the linear probe duplicate detector
// sequences clearing, hashing, reduction and probing; depends on lpdd_pkg
module lpdd_ctrl
  import lpdd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  output cmd_t  cmd,
  input  stat_t stat
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != S_IDLE);
    case (state)
      S_INIT: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = stat.wipe_needed ? S_WIPE : S_MUL;
        end
      end
      S_WIPE: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_last) begin
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.reduce_step = 1'b1;
        if (stat.reduce_last) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.hit_empty || stat.hit_match || stat.probe_last) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/lpdd_dpath.sv
// datapath for the linear probe duplicate detector
// hash multiplier, slot reduction, slot memory, probe counters and result register; uses lpdd_pkg
module lpdd_dpath
  import lpdd_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  item_t   item,
  output stat_t   stat,
  output result_t result,
  output logic    done
);

  localparam int unsigned IDX_W  = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned WORD_W = 2 * ID_W + 1;
  localparam bit          POW2   = ((NUM_SLOTS & (NUM_SLOTS - 1)) == 0);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(NUM_SLOTS - 1);
  localparam int unsigned FOLD_N = ID_W / 8;
  localparam int unsigned SUM_W  = IDX_W + 11;
  localparam int unsigned QUO_W  = 11;
  localparam int unsigned RCP_SH = SUM_W + IDX_W;
  localparam logic [SUM_W:0] RCP =
    (SUM_W + 1)'(((64'd1 << RCP_SH) / 64'(NUM_SLOTS)) + 64'd1);

  // residue of each byte weight modulo the slot count
  function automatic logic [FOLD_N*IDX_W-1:0] fold_residues();
    logic [FOLD_N*IDX_W-1:0] tbl;
    logic [63:0]             r;
    tbl = '0;
    r   = 64'd1 % 64'(NUM_SLOTS);
    for (int i = 0; i < FOLD_N; i++) begin
      tbl[i*IDX_W +: IDX_W] = IDX_W'(r);
      r = (r << 8) % 64'(NUM_SLOTS);
    end
    return tbl;
  endfunction

  localparam logic [FOLD_N*IDX_W-1:0] FOLD_RES = fold_residues();

  logic [WORD_W-1:0] mem [NUM_SLOTS];
  logic [WORD_W-1:0] rd_word;

  logic [ID_W-1:0]   lo;
  logic [ID_W-1:0]   hi;
  logic [ID_W-1:0]   mixed;
  logic [ID_W-1:0]   acc;
  logic [1:0]        mul_cnt;
  logic [1:0]        red_cnt;
  logic [SUM_W-1:0]  fold_sum;
  logic [QUO_W-1:0]  quot;
  logic [IDX_W-1:0]  slot;
  logic [IDX_W-1:0]  probe_cnt;
  logic [IDX_W-1:0]  clr_addr;
  logic [CNT_W-1:0]  entry_count;
  logic              distinct;

  logic [ID_W-1:0]   folded;
  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [ID_W-1:0]   prod;
  logic [ID_W-1:0]   acc_next;
  logic [ID_W-1:0]   hash;
  logic [SUM_W-1:0]  fold_next;
  logic [2*SUM_W:0]  rcp_prod;
  logic [SUM_W-1:0]  rem_full;
  logic              rd_used;
  logic              rd_eq;
  logic              insert;
  logic              finish;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;

  // hash front end and multiply by partial products
  assign folded   = item.id_low ^ item.id_high;
  assign mul_a    = (mul_cnt == 2'd2) ? mixed[ID_W-1:HALF_W] : mixed[HALF_W-1:0];
  assign mul_b    = (mul_cnt == 2'd1) ? HASH_MUL[ID_W-1:HALF_W] : HASH_MUL[HALF_W-1:0];
  assign prod     = ID_W'(mul_a) * ID_W'(mul_b);
  assign acc_next = (mul_cnt == 2'd0) ? prod : acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
  assign hash     = acc ^ (acc >> HASH_SHIFT);

  // remainder by the slot count: byte residues, reciprocal multiply, subtract
  always_comb begin
    fold_next = '0;
    for (int i = 0; i < FOLD_N; i++) begin
      fold_next = fold_next + SUM_W'(hash[i*8 +: 8]) * SUM_W'(FOLD_RES[i*IDX_W +: IDX_W]);
    end
  end

  assign rcp_prod = (2*SUM_W+1)'(fold_sum) * (2*SUM_W+1)'(RCP);
  assign rem_full = fold_sum - SUM_W'(quot) * SUM_W'(NUM_SLOTS);

  // probe compare
  assign rd_used = rd_word[WORD_W-1];
  assign rd_eq   = (rd_word[2*ID_W-1:ID_W] == lo) && (rd_word[ID_W-1:0] == hi);
  assign insert  = cmd.check && !rd_used;
  assign finish  = cmd.check && (!rd_used || rd_eq || (probe_cnt == LAST_SLOT));

  always_comb begin
    stat.wipe_needed = item.first_of_set && (entry_count != '0);
    stat.clear_last  = (clr_addr == LAST_SLOT);
    stat.mul_last    = (mul_cnt == 2'(MUL_STEPS - 1));
    stat.reduce_last = POW2 ? 1'b1 : (red_cnt == 2'(RED_STEPS - 1));
    stat.hit_empty   = !rd_used;
    stat.hit_match   = rd_used && rd_eq;
    stat.probe_last  = (probe_cnt == LAST_SLOT);
  end

  // memory write port shared by the clearing pass and inserts
  always_comb begin
    we    = cmd.clear_step || insert;
    waddr = cmd.clear_step ? clr_addr : slot;
    wdata = cmd.clear_step ? '0 : {1'b1, lo, hi};
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_word <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo        <= item.id_low;
      hi        <= item.id_high;
      mixed     <= folded ^ (folded >> HASH_SHIFT);
      mul_cnt   <= '0;
      red_cnt   <= '0;
      slot      <= '0;
      probe_cnt <= '0;
    end
    if (cmd.mul_step) begin
      acc     <= acc_next;
      mul_cnt <= mul_cnt + 2'd1;
    end
    if (cmd.reduce_step) begin
      if (red_cnt == 2'd0) begin
        fold_sum <= fold_next;
      end
      if (red_cnt == 2'd1) begin
        quot <= rcp_prod[RCP_SH +: QUO_W];
      end
      slot    <= POW2 ? hash[IDX_W-1:0] : rem_full[IDX_W-1:0];
      red_cnt <= red_cnt + 2'd1;
    end
    if (cmd.check && !finish) begin
      slot      <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
      probe_cnt <= probe_cnt + 1'b1;
    end
    if (finish) begin
      result.status       <= !rd_used ? ST_NEW : (rd_eq ? ST_DUP : ST_FULL);
      result.all_distinct <= distinct && !rd_used;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      entry_count <= '0;
      distinct    <= 1'b1;
      done        <= 1'b0;
    end else begin
      done <= finish;
      if (cmd.clear_step) begin
        clr_addr <= stat.clear_last ? '0 : clr_addr + 1'b1;
      end
      if (cmd.load && item.first_of_set) begin
        entry_count <= '0;
        distinct    <= 1'b1;
      end
      if (insert) begin
        entry_count <= entry_count + 1'b1;
      end
      if (finish && rd_used) begin
        distinct <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(NUM_SLOTS))
    else $error("entry count beyond slot count");

  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    insert && !cmd.load |=> entry_count == $past(entry_count) + 1'b1)
    else $error("insert did not advance entry count");

  a_no_clear_in_probe: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> !cmd.read && !cmd.check && !cmd.mul_step)
    else $error("clearing pass overlaps an item");
`endif

endmodule

// File: design/linear_probe_duplicate_detector.sv
// top level of the linear probe duplicate detector
// joins lpdd_ctrl and lpdd_dpath; uses lpdd_pkg
//
// An identity is taken when start is high and busy is low. Its result appears on result
// for one cycle with done high and cannot be held off. An item passes through the shared
// 32x32 multiplier, takes its home slot, then for each probed slot a registered memory read
// and a compare, and finally the result register. For a slot count that is not a power of
// two the hash is reduced by byte residues, reciprocal multiply and subtract before the
// home slot is taken. An item with first_of_set on a non-empty set adds a clearing pass
// over all slots, and after reset busy stays high while the slot memory is cleared.
module linear_probe_duplicate_detector
  import lpdd_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  cmd_t  cmd;
  stat_t stat;

  lpdd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  lpdd_dpath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .stat   (stat),
    .result (result),
    .done   (done)
  );

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("transfer accepted without going busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_NEW || result.status == ST_DUP || result.status == ST_FULL))
    else $error("bad status code");

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_NEW |-> !result.all_distinct)
    else $error("distinct flag set after duplicate or full");
`endif

endmodule

// File: tb/tb_linear_probe_duplicate_detector.sv
`timescale 1ns / 100ps
// self-checking testbench for the linear probe duplicate detector: directed corner identities
// and random sets rich in hash collisions; depends on lpdd_pkg
module tb_linear_probe_duplicate_detector;
  import lpdd_pkg::*;

  localparam int unsigned SLOTS      = NUM_SLOTS_DEF;
  localparam int          QUIET_MAX  = 20000;
  localparam int          DRAIN_WAIT = 40;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    done;
  result_t result;

  item_t   identity_queue[$];
  item_t   set_members[$];
  result_t insert_outcomes[$];

  bit          set_used[SLOTS];
  logic [63:0] set_low[SLOTS];
  logic [63:0] set_high[SLOTS];
  bit          distinct_flag = 1'b1;

  int gap_left     = 0;
  int no_idle_left = 0;
  int quiet_cycles = 0;
  int error_count  = 0;

  linear_probe_duplicate_detector #(.NUM_SLOTS(SLOTS)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always #2 clk = ~clk;

  function automatic int unsigned home_slot_of(logic [63:0] lo, logic [63:0] hi);
    logic [63:0] v;
    v = lo ^ hi;
    v = v ^ (v >> HASH_SHIFT);
    v = v * HASH_MUL;
    v = v ^ (v >> HASH_SHIFT);
    return 32'(v % 64'(SLOTS));
  endfunction

  task automatic predict_insert(input item_t it);
    int unsigned slot;
    result_t     outcome;
    if (it.first_of_set) begin
      foreach (set_used[i]) set_used[i] = 1'b0;
      distinct_flag = 1'b1;
    end
    slot = home_slot_of(it.id_low, it.id_high);
    outcome.status = ST_FULL;
    for (int n = 0; n < SLOTS; n++) begin
      if (!set_used[slot]) begin
        set_used[slot] = 1'b1;
        set_low[slot]  = it.id_low;
        set_high[slot] = it.id_high;
        outcome.status = ST_NEW;
        break;
      end
      if (set_low[slot] == it.id_low && set_high[slot] == it.id_high) begin
        outcome.status = ST_DUP;
        break;
      end
      slot = (slot + 1) % SLOTS;
    end
    if (outcome.status != ST_NEW) distinct_flag = 1'b0;
    outcome.all_distinct = distinct_flag;
    insert_outcomes.push_back(outcome);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic queue_identity(input logic [63:0] lo, input logic [63:0] hi, input logic first);
    item_t it;
    it.id_low       = lo;
    it.id_high      = hi;
    it.first_of_set = first;
    identity_queue.push_back(it);
    if (first) set_members.delete();
    set_members.push_back(it);
  endtask

  // a set opened by first_of_set, then fresh, repeated and same-home identities, some of which open a new set
  task automatic queue_random_set(input int length);
    logic [63:0] k;
    item_t       pick;
    int          choice;
    queue_identity(rand64(), rand64(), 1'b1);
    for (int n = 1; n < length; n++) begin
      choice = $urandom_range(0, 99);
      pick   = set_members[$urandom_range(0, set_members.size() - 1)];
      k      = rand64();
      if (choice < 40) queue_identity(rand64(), rand64(), 1'b0);
      else if (choice < 60) queue_identity(pick.id_low, pick.id_high, 1'b0);
      else if (choice < 85) queue_identity(pick.id_low ^ k, pick.id_high ^ k, 1'b0);
      else if (choice < 90) queue_identity(k, k, 1'b0);
      else if (choice < 95) queue_identity(rand64(), rand64(), 1'b1);
      else queue_identity(pick.id_low ^ k, pick.id_high ^ k, 1'b1);
    end
  endtask

  // driver: one transfer per start while not busy
  always @(posedge clk) begin : drive_items
    logic  next_start;
    item_t next_item;
    int    next_gap;
    int    next_burst;
    int    roll;
    next_start = start;
    next_item  = item;
    next_gap   = gap_left;
    next_burst = no_idle_left;
    if (rst) begin
      next_start = 1'b0;
      next_item  = '0;
      next_gap   = 0;
      next_burst = 0;
    end else begin
      if (start && !busy) begin
        predict_insert(item);
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (next_gap > 0) begin
          next_gap--;
        end else if (identity_queue.size() != 0) begin
          next_item  = identity_queue.pop_front();
          next_start = 1'b1;
          if (next_burst > 0) begin
            next_gap = 0;
            next_burst--;
          end else begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
              next_gap   = 0;
              next_burst = $urandom_range(10, 40);
            end else if (roll < 50) next_gap = 0;
            else if (roll < 85) next_gap = $urandom_range(1, 3);
            else if (roll < 97) next_gap = $urandom_range(4, 12);
            else next_gap = $urandom_range(20, 80);
          end
        end
      end
    end
    start        <= next_start;
    item         <= next_item;
    gap_left     <= next_gap;
    no_idle_left <= next_burst;
  end

  // monitor: every done strobe is a result transfer
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && done) begin
      if (insert_outcomes.size() == 0) begin
        $error("unexpected result: status %0d all_distinct %0d", result.status,
               result.all_distinct);
        error_count++;
      end else begin
        want = insert_outcomes.pop_front();
        if (result.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, result.status);
          error_count++;
        end
        if (result.all_distinct !== want.all_distinct) begin
          $error("all_distinct: expected %0d, actual %0d", want.all_distinct,
                 result.all_distinct);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [63:0] wrap_x;
    logic [63:0] r;

    // directed corners
    queue_identity('0, '0, 1'b1);
    queue_identity('0, '0, 1'b0);
    queue_identity('1, '1, 1'b0);
    queue_identity('1, '0, 1'b0);
    queue_identity('0, '1, 1'b0);
    queue_identity('0, '1, 1'b0);
    queue_identity({32{2'b10}}, {32{2'b01}}, 1'b0);
    queue_identity({32{2'b01}}, {32{2'b10}}, 1'b0);
    queue_identity('1, '1, 1'b0);
    queue_identity('1, '0, 1'b1);
    queue_identity('1, '0, 1'b0);
    queue_identity({32{2'b10}}, {32{2'b10}}, 1'b1);

    // same-home identities starting at the last slot, so the probe wraps
    do wrap_x = rand64(); while (home_slot_of(wrap_x, '0) != SLOTS - 1);
    for (int n = 0; n < 4; n++) begin
      r = rand64();
      queue_identity(r, r ^ wrap_x, n == 0);
    end
    queue_identity(set_members[3].id_low, set_members[3].id_high, 1'b0);
    queue_identity(set_members[0].id_low, set_members[0].id_high, 1'b0);
    queue_identity(wrap_x, '0, 1'b0);
    queue_identity('0, wrap_x, 1'b0);

    while (identity_queue.size() < 500) queue_random_set($urandom_range(1, 50));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (identity_queue.size() != 0 || start || insert_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && insert_outcomes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
